/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the HDLC encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_s, rst_n_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
    else $error("assertion failed");
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk_s, rst_n_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk_s, rst_n_s, prop)
`define ASSERT_IMPLY(label, clk_s, rst_n_s, ante, cons)
`endif
`endif

/* rtl/hnbe_pkg.sv */
// Shared types and constants of the HDLC NRZI bit encoder.
package hnbe_pkg;

  // Action codes of an input beat
  localparam logic [1:0] ACT_DATA    = 2'd0;
  localparam logic [1:0] ACT_CRC_RST = 2'd1;
  localparam logic [1:0] ACT_CRC_APP = 2'd2;

  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [3:0]  ONES_MAX    = 4'd15;
  localparam logic [3:0]  STUFF_AFTER = 4'd5;
  localparam logic [4:0]  BYTE_BITS   = 5'd8;
  localparam logic [4:0]  CRC_BITS    = 5'd16;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_data;
    logic load_crc;
    logic crc_init;
    logic send_bit;
    logic send_stuff;
  } hnbe_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic slot_free;
    logic stuff_pend;
    logic cnt_one;
    logic cnt_zero;
  } hnbe_sts_t;

endpackage

/* rtl/hdlc_nrzi_bit_encoder_with_crc_unit.sv */
// Top level of the HDLC NRZI bit encoder with CRC-16.
// Each input beat is one byte action: send a data byte LSB first (optional
// bit stuffing after five ones), reset the CRC to all ones, or append the
// inverted CRC low byte then high byte with stuffing always on; action 3 is
// dropped. Each line bit leaves as one result beat carrying the NRZI tone
// level, a stuffing flag and a last-bit flag. The controller walks one line
// bit per cycle through the datapath shifter while the single output register
// is free, so a stalled result consumer holds it back. A data byte becomes 8
// to 10 line bits, a CRC append 16 to 20, stuffing included, a CRC reset none;
// a new beat is taken only after the last line bit of the one before is sent.
module hdlc_nrzi_bit_encoder_with_crc_unit
  import hnbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_data_byte,
  input  logic       in_stuff_enable,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_tone_level,
  output logic       out_stuffed_bit,
  output logic       out_last_bit
);

`include "assert_macros.svh"

  hnbe_cmd_t cmd;
  hnbe_sts_t sts;

  hnbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd)
  );

  hnbe_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .in_stuff_enable (in_stuff_enable),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tone_level  (out_tone_level),
    .out_stuffed_bit (out_stuffed_bit),
    .out_last_bit    (out_last_bit)
  );

  // Controller issues at most one command per cycle
  `ASSERT_ALWAYS(a_cmd_onehot, clk, rst_n, $onehot0(cmd))
  // A line bit is only written when the output register can take it
  `ASSERT_IMPLY(a_emit_slot, clk, rst_n, cmd.send_bit || cmd.send_stuff, sts.slot_free)
  // No line bit is produced while a new beat may be accepted
  `ASSERT_IMPLY(a_idle_quiet, clk, rst_n, in_ready, !(cmd.send_bit || cmd.send_stuff))

endmodule

/* rtl/hnbe_ctrl.sv */
// Controller state machine: sequences data or CRC bits and stuffing bits of one beat.
module hnbe_ctrl
  import hnbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  hnbe_sts_t  sts,
  output hnbe_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SEND  = 2'd1;
  localparam logic [1:0] ST_STUFF = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Decode the state and the incoming action into commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_DATA: begin
              cmd.load_data = 1'b1;
              state_nxt     = ST_SEND;
            end
            ACT_CRC_RST: cmd.crc_init = 1'b1;
            ACT_CRC_APP: begin
              cmd.load_crc = 1'b1;
              state_nxt    = ST_SEND;
            end
            default: ;
          endcase
        end
      end
      ST_SEND: begin
        if (sts.slot_free) begin
          cmd.send_bit = 1'b1;
          if (sts.stuff_pend) begin
            state_nxt = ST_STUFF;
          end else if (sts.cnt_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_STUFF: begin
        if (sts.slot_free) begin
          cmd.send_stuff = 1'b1;
          state_nxt      = sts.cnt_zero ? ST_IDLE : ST_SEND;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/hnbe_dp.sv */
// Datapath: bit shifter, CRC-16, NRZI tone, ones-run counter and output register.
module hnbe_dp
  import hnbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_data_byte,
  input  logic       in_stuff_enable,
  input  hnbe_cmd_t  cmd,
  output hnbe_sts_t  sts,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_tone_level,
  output logic       out_stuffed_bit,
  output logic       out_last_bit
);

  logic [15:0] shift_r;
  logic [4:0]  cnt_r;
  logic        stuff_r;
  logic [15:0] crc_r;
  logic [3:0]  ones_r;
  logic        tone_r;
  logic        out_valid_r;
  logic        out_tone_r;
  logic        out_stuffed_r;
  logic        out_last_r;

  logic        cur_bit;
  logic [3:0]  ones_inc;
  logic [15:0] crc_step;

  assign cur_bit  = shift_r[0];
  assign ones_inc = (ones_r == ONES_MAX) ? ONES_MAX : ones_r + 4'd1;
  assign crc_step = (crc_r >> 1) ^ (((crc_r[0] ^ cur_bit) == 1'b1) ? CRC_POLY : 16'h0000);

  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.stuff_pend = cur_bit && stuff_r && (ones_inc == STUFF_AFTER);
  assign sts.cnt_one    = (cnt_r == 5'd1);
  assign sts.cnt_zero   = (cnt_r == 5'd0);

  // Load the shifter, then shift one data bit per send
  always_ff @(posedge clk) begin
    if (cmd.load_data) begin
      shift_r <= {8'h00, in_data_byte};
      cnt_r   <= BYTE_BITS;
      stuff_r <= in_stuff_enable;
    end else if (cmd.load_crc) begin
      shift_r <= ~crc_r;
      cnt_r   <= CRC_BITS;
      stuff_r <= 1'b1;
    end else if (cmd.send_bit) begin
      shift_r <= shift_r >> 1;
      cnt_r   <= cnt_r - 5'd1;
    end
  end

  // Reset or update the CRC on each shifter bit, tone and ones run on each line bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      ones_r <= 4'd0;
      tone_r <= 1'b0;
    end else begin
      if (cmd.crc_init) begin
        crc_r <= CRC_INIT;
      end else if (cmd.send_bit) begin
        crc_r <= crc_step;
      end
      if (cmd.send_bit) begin
        if (cur_bit) begin
          ones_r <= ones_inc;
        end else begin
          ones_r <= 4'd0;
          tone_r <= ~tone_r;
        end
      end else if (cmd.send_stuff) begin
        ones_r <= 4'd0;
        tone_r <= ~tone_r;
      end
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.send_bit || cmd.send_stuff) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send_bit) begin
      out_tone_r    <= cur_bit ? tone_r : ~tone_r;
      out_stuffed_r <= 1'b0;
      out_last_r    <= sts.cnt_one && !sts.stuff_pend;
    end else if (cmd.send_stuff) begin
      out_tone_r    <= ~tone_r;
      out_stuffed_r <= 1'b1;
      out_last_r    <= sts.cnt_zero;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tone_level  = out_tone_r;
  assign out_stuffed_bit = out_stuffed_r;
  assign out_last_bit    = out_last_r;

endmodule

/* verif/tb.sv */
// Testbench for the HDLC NRZI bit encoder with CRC-16 append and bit stuffing.
`timescale 1ns / 1ps

module tb;
  import hnbe_pkg::*;

  // Action 3 has no meaning and is dropped by the encoder
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int MAX_GAP      = 14;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_TICKS = 40;

  typedef struct packed {
    logic tone;
    logic stuffed;
    logic last;
  } line_bit_t;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_ready;
  logic [1:0] in_action       = ACT_DATA;
  logic [7:0] in_data_byte    = 8'h00;
  logic       in_stuff_enable = 1'b0;
  logic       out_valid;
  logic       out_ready       = 1'b0;
  logic       out_tone_level;
  logic       out_stuffed_bit;
  logic       out_last_bit;

  // Encoder state mirrored by the predictor
  logic [15:0] crc_acc   = CRC_INIT;
  logic [3:0]  ones_cnt  = '0;
  logic        line_tone = 1'b0;

  line_bit_t   line_bits_q[$];
  line_bit_t   exp_bit;

  // Idle control of both channels
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  int rx_wait     = 0;
  int rx_hold_req = 0;
  int rx_hold_cnt = 0;

  int err_cnt     = 0;
  int bits_seen   = 0;
  int beats_data  = 0;
  int beats_rst   = 0;
  int beats_app   = 0;
  int beats_drop  = 0;

  hdlc_nrzi_bit_encoder_with_crc_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .in_stuff_enable (in_stuff_enable),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tone_level  (out_tone_level),
    .out_stuffed_bit (out_stuffed_bit),
    .out_last_bit    (out_last_bit)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("hdlc_nrzi_bit_encoder_with_crc_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Line bit predictor
  // ---------------------------------------------------------------------
  function automatic void push_line_bit(logic stuffed);
    line_bit_t lb;
    lb.tone    = line_tone;
    lb.stuffed = stuffed;
    lb.last    = 1'b0;
    line_bits_q.push_back(lb);
  endfunction

  // Shift a byte out LSB first: NRZI, CRC on data bits, optional stuffing
  function automatic void shift_byte(logic [7:0] value, logic stuff_on);
    logic bitv;
    logic fb;
    for (int i = 0; i < 8; i++) begin
      bitv    = value[i];
      fb      = crc_acc[0] ^ bitv;
      crc_acc = crc_acc >> 1;
      if (fb) begin
        crc_acc = crc_acc ^ CRC_POLY;
      end
      if (bitv) begin
        push_line_bit(1'b0);
        if (ones_cnt < ONES_MAX) begin
          ones_cnt = ones_cnt + 4'd1;
        end
        if (stuff_on && ones_cnt == STUFF_AFTER) begin
          line_tone = ~line_tone;
          push_line_bit(1'b1);
          ones_cnt = '0;
        end
      end else begin
        line_tone = ~line_tone;
        push_line_bit(1'b0);
        ones_cnt = '0;
      end
    end
  endfunction

  function automatic void encode_action(logic [1:0] act, logic [7:0] value, logic stuff_on);
    int         depth;
    logic [7:0] lo;
    logic [7:0] hi;
    depth = line_bits_q.size();
    case (act)
      ACT_DATA: begin
        shift_byte(value, stuff_on);
        beats_data++;
      end
      ACT_CRC_RST: begin
        crc_acc = CRC_INIT;
        beats_rst++;
      end
      ACT_CRC_APP: begin
        // Both bytes come from the CRC as it stands before the append
        lo = ~crc_acc[7:0];
        hi = ~crc_acc[15:8];
        shift_byte(lo, 1'b1);
        shift_byte(hi, 1'b1);
        beats_app++;
      end
      default: begin
        beats_drop++;
      end
    endcase
    if (line_bits_q.size() > depth) begin
      line_bits_q[line_bits_q.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------
  task automatic send_beat(logic [1:0] act, logic [7:0] value, logic stuff_on);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    in_valid = 1'b0;
    repeat (gap) @(negedge clk);
    in_valid        = 1'b1;
    in_action       = act;
    in_data_byte    = value;
    in_stuff_enable = stuff_on;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    encode_action(act, value, stuff_on);
  endtask

  // Drop valid and hold until every predicted line bit has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (line_bits_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result receiver: per-beat wait plus an occasional long hold
  // ---------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        rx_hold_cnt = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold_cnt > 0) begin
        out_ready = 1'b0;
        rx_hold_cnt--;
      end else if (rx_wait > 0) begin
        out_ready = 1'b0;
        rx_wait--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic want, logic got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: line bit %0d %s mismatch: expected %0b, actual %0b",
               $time, bits_seen, name, want, got);
    end
  endtask

  // Compare each accepted line bit with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (line_bits_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected line bit: expected none, actual tone=%0b stuffed=%0b last=%0b",
                 $time, out_tone_level, out_stuffed_bit, out_last_bit);
      end else begin
        exp_bit = line_bits_q.pop_front();
        check_field("tone_level", exp_bit.tone, out_tone_level);
        check_field("stuffed_bit", exp_bit.stuffed, out_stuffed_bit);
        check_field("last_bit", exp_bit.last, out_last_bit);
      end
      bits_seen++;
      rx_wait = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 5))
      0:       return 8'hFF;
      1:       return 8'h7E;
      2:       return 8'($urandom | $urandom);
      default: return 8'($urandom);
    endcase
  endfunction

  // Field extremes, every action, stuffing and saturation corners
  task automatic test_directed();
    send_beat(ACT_DATA, 8'h7E, 1'b0);
    send_beat(ACT_CRC_RST, 8'h00, 1'b0);
    send_beat(ACT_DATA, 8'h00, 1'b1);
    send_beat(ACT_DATA, 8'hFF, 1'b1);
    send_beat(ACT_DATA, 8'h1F, 1'b1);
    send_beat(ACT_DATA, 8'hF8, 1'b1);
    send_beat(ACT_DATA, 8'hAA, 1'b0);
    send_beat(ACT_DATA, 8'h55, 1'b1);
    send_beat(ACT_CRC_APP, 8'h00, 1'b0);
    send_beat(ACT_DATA, 8'h7E, 1'b0);
    send_beat(ACT_UNUSED, 8'hFF, 1'b1);
    // Run of ones with stuffing off saturates the counter
    send_beat(ACT_DATA, 8'hFF, 1'b0);
    send_beat(ACT_DATA, 8'hFF, 1'b0);
    send_beat(ACT_DATA, 8'hFF, 1'b1);
    // CRC reset leaves the run count and tone alone
    send_beat(ACT_CRC_RST, 8'hFF, 1'b1);
    send_beat(ACT_DATA, 8'h3F, 1'b1);
    send_beat(ACT_CRC_APP, 8'hFF, 1'b1);
    send_beat(ACT_CRC_APP, 8'h5A, 1'b0);
    send_beat(ACT_UNUSED, 8'h00, 1'b0);
    send_beat(ACT_DATA, 8'hFF, 1'b1);
    send_beat(ACT_CRC_RST, 8'h81, 1'b0);
    send_beat(ACT_CRC_APP, 8'h18, 1'b1);
    send_beat(ACT_DATA, 8'h7E, 1'b0);
    wait_drained();
  endtask

  // Flag, CRC reset, payload, CRC append, flag
  task automatic send_frame();
    int n;
    n = $urandom_range(1, 6);
    send_beat(ACT_DATA, 8'h7E, 1'b0);
    send_beat(ACT_CRC_RST, 8'($urandom), 1'($urandom));
    repeat (n) send_beat(ACT_DATA, pick_payload(), $urandom_range(0, 7) != 0);
    send_beat(ACT_CRC_APP, 8'($urandom), 1'($urandom));
    send_beat(ACT_DATA, 8'h7E, 1'b0);
  endtask

  // Mostly well-formed frames with random content, the rest noise
  task automatic test_random_frames(int beat_goal);
    int start;
    logic [1:0] act;
    start = beats_data + beats_rst + beats_app;
    while (beats_data + beats_rst + beats_app - start < beat_goal) begin
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 4) != 0) begin
        send_frame();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          act = 2'($urandom_range(0, 3));
          send_beat(act, 8'($urandom), 1'($urandom));
        end
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    wait_drained();
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering beats
  task automatic test_backpressure();
    tx_idle_on  = 1'b0;
    rx_hold_req = LONG_HOLD;
    repeat (4) send_frame();
    // Pause until everything is out, then resume
    wait_drained();
    send_frame();
    tx_idle_on = 1'b1;
    wait_drained();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_full_rate();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (2) send_frame();
    repeat (6) send_beat(2'($urandom_range(0, 3)), pick_payload(), 1'($urandom));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_random_frames(180);
    test_full_rate();

    while (line_bits_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (line_bits_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d line bits predicted but never seen", $time, line_bits_q.size());
    end

    $display("Sent %0d data beats, %0d CRC resets, %0d CRC appends, %0d dropped beats;",
             beats_data, beats_rst, beats_app, beats_drop);
    $display("checked %0d line bits under random idling, a long output stall and full rate.",
             bits_seen);
    if (err_cnt == 0) begin
      $display("hdlc_nrzi_bit_encoder_with_crc_unit test passed");
    end else begin
      $display("hdlc_nrzi_bit_encoder_with_crc_unit test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/hnbe_pkg.sv
rtl/hnbe_ctrl.sv
rtl/hnbe_dp.sv
rtl/hdlc_nrzi_bit_encoder_with_crc_unit.sv
verif/tb.sv
